// ===== hw/rtl/sorted_unique_set_insert_top_macros.svh =====
// Assertion helpers used by the sorted set top module.
`ifndef SORTED_UNIQUE_SET_INSERT_TOP_MACROS_SVH
`define SORTED_UNIQUE_SET_INSERT_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SUSI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SUSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/susi_pkg.sv =====
package susi_pkg;

    localparam logic [63:0] SIGN_BIT       = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ABS_MASK       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] EXP_ALL        = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] MINUS_ONE_BITS = 64'hBFF0_0000_0000_0000;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_READ_OK  = 3'd3,
        ST_BAD_POS  = 3'd4
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_PUSH   = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    // Token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic        valid;
        op_t         op;
        phase_t      phase;
        logic        full;
        logic [63:0] carry;
        logic [6:0]  pos;
        logic [63:0] rdata;
        status_t     status;
    } tok_t;

    function automatic logic is_nan(input logic [63:0] b);
        return (b & ABS_MASK) > EXP_ALL;
    endfunction

    // Monotone unsigned key; both zeros map to one key.
    function automatic logic [63:0] order_key(input logic [63:0] b);
        logic [63:0] k;
        if ((b & ABS_MASK) == 64'd0) begin
            k = SIGN_BIT;
        end else if (b[63]) begin
            k = ~b;
        end else begin
            k = b | SIGN_BIT;
        end
        return k;
    endfunction

    function automatic logic fp_eq(input logic [63:0] a, input logic [63:0] b);
        return !is_nan(a) && !is_nan(b) && (order_key(a) == order_key(b));
    endfunction

    function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
        return !is_nan(a) && !is_nan(b) && (order_key(a) < order_key(b));
    endfunction

endpackage

// ===== hw/rtl/sorted_unique_set_insert_top.sv =====
// Sorted set of IEEE doubles, ascending and free of duplicates, up to CAPACITY
// entries (+0 and -0 count as one value). Each beat on s_ is an insert
// (s_mode 0) or a read of the 1-based s_position (s_mode 1); each gives exactly
// one beat on m_. The store is a row of CAPACITY cells; a token carrying the
// item walks the row one cell per cycle, comparing, swapping larger entries
// one place up on insert, or picking up the entry on read. One item is in the
// row at a time: a new item is not accepted until the previous one has left
// the last cell. A finished result waits in an output register (with one
// spare slot), so the next item is taken while the previous result is still
// unclaimed. Status: 0 inserted, 1 duplicate, 2 full (value dropped), 3 read
// ok, 4 position out of range (read data -1.0).
`include "sorted_unique_set_insert_top_macros.svh"

module sorted_unique_set_insert_top #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [63:0] s_value_bits,
    input  logic [6:0]  s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_read_bits,
    output logic [2:0]  m_status,
    output logic [6:0]  m_entry_count
);
    import susi_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [63:0] rbits;
        status_t     status;
        logic [6:0]  cnt;
    } res_t;

    tok_t             chain [CAPACITY+1];
    tok_t             inject;
    tok_t             exit_tok;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             busy_reg;
    logic             in_acc;
    logic             out_free;
    logic             m_valid_reg;
    res_t             out_reg;
    logic             pend_valid_reg;
    res_t             pend_reg;
    res_t             exit_res;

    // Hold off input beats during reset.
    assign s_ready  = aresetn && !busy_reg && !pend_valid_reg;
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Build the token at the head of the row.
    always_comb begin
        inject.valid = in_acc;
        inject.op    = s_mode ? OP_READ : OP_INSERT;
        inject.phase = PH_SEARCH;
        inject.full  = count_reg == CNT_W'(CAPACITY);
        inject.carry = s_value_bits;
        inject.pos   = s_position;
        if (s_mode) begin
            inject.rdata  = MINUS_ONE_BITS;
            inject.status = ST_BAD_POS;
        end else begin
            inject.rdata  = 64'd0;
            inject.status = inject.full ? ST_FULL : ST_INSERTED;
        end
    end

    assign chain[0] = inject;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        susi_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .count   (count_reg),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign exit_tok = chain[CAPACITY];

    // Grow the count only on a real insert leaving the row.
    always_comb begin
        count_next = count_reg;
        if (exit_tok.valid && exit_tok.op == OP_INSERT && exit_tok.status == ST_INSERTED) begin
            count_next = count_reg + CNT_W'(1);
        end
        exit_res.rbits  = exit_tok.rdata;
        exit_res.status = exit_tok.status;
        exit_res.cnt    = 7'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            busy_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (in_acc) begin
                busy_reg <= 1'b1;
            end else if (exit_tok.valid) begin
                busy_reg <= 1'b0;
            end
            // Drain the spare slot first; hold a new result there if the output register is still occupied.
            if (pend_valid_reg && out_free) begin
                out_reg        <= pend_reg;
                m_valid_reg    <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (exit_tok.valid && out_free) begin
                out_reg     <= exit_res;
                m_valid_reg <= 1'b1;
            end else begin
                if (exit_tok.valid) begin
                    pend_reg       <= exit_res;
                    pend_valid_reg <= 1'b1;
                end
                if (out_free) begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_bits   = out_reg.rbits;
    assign m_status      = out_reg.status;
    assign m_entry_count = out_reg.cnt;

    `SUSI_ASSERT_IMPLY(a_exit_busy, exit_tok.valid, busy_reg, "token left row while idle")
    `SUSI_ASSERT_IMPLY(a_cnt_max, 1'b1, count_reg <= CNT_W'(CAPACITY), "count over capacity")
    `SUSI_ASSERT_NEXT(a_acc_busy, in_acc, busy_reg, "accept did not mark busy")
    `SUSI_ASSERT_IMPLY(a_exit_slot, exit_tok.valid, !pend_valid_reg, "result with spare slot taken")

endmodule

// ===== hw/rtl/susi_cell.sv =====
module susi_cell #(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [CNT_W-1:0] count,
    input  susi_pkg::tok_t tok_in,
    output susi_pkg::tok_t tok_out
);
    import susi_pkg::*;

    localparam int PW = (CNT_W > 7) ? CNT_W : 7;

    logic [63:0] data_reg;
    logic [63:0] data_next;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        occ;
    logic        pos_hit;

    assign occ     = CNT_W'(INDEX) < count;
    assign pos_hit = PW'(tok_in.pos) == PW'(INDEX + 1);

    always_comb begin
        tok_next  = tok_in;
        data_next = data_reg;
        if (tok_in.valid) begin
            if (tok_in.op == OP_INSERT) begin
                case (tok_in.phase)
                    PH_SEARCH: begin
                        if (occ) begin
                            if (fp_eq(data_reg, tok_in.carry)) begin
                                tok_next.phase  = PH_DONE;
                                tok_next.status = ST_DUP;
                            end else if (!tok_in.full && fp_lt(tok_in.carry, data_reg)) begin
                                // take the new value, push the old one onward
                                data_next      = tok_in.carry;
                                tok_next.carry = data_reg;
                                tok_next.phase = PH_PUSH;
                            end
                        end else if (!tok_in.full) begin
                            data_next       = tok_in.carry;
                            tok_next.phase  = PH_DONE;
                            tok_next.status = ST_INSERTED;
                        end
                    end
                    PH_PUSH: begin
                        data_next = tok_in.carry;
                        if (occ) begin
                            tok_next.carry = data_reg;
                        end else begin
                            tok_next.phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end else if (tok_in.phase == PH_SEARCH && occ && pos_hit) begin
                tok_next.rdata  = data_reg;
                tok_next.status = ST_READ_OK;
                tok_next.phase  = PH_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import susi_pkg::*;

    localparam int DEPTH     = 64;
    localparam int RAND_ITEMS = 1200;
    // Each item walks the whole cell row before the next one enters.
    localparam int ITEM_CYCLES = DEPTH + 2;

    typedef struct packed {
        op_t         op;
        logic [63:0] value_bits;
        logic [6:0]  position;
    } set_op_t;

    typedef struct packed {
        logic [63:0] read_bits;
        status_t     status;
        logic [6:0]  entry_count;
    } set_reply_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [63:0] s_value_bits;
    logic [6:0]  s_position;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_read_bits;
    logic [2:0]  m_status;
    logic [6:0]  m_entry_count;

    sorted_unique_set_insert_top #(.CAPACITY(DEPTH)) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_value_bits (s_value_bits),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_bits  (m_read_bits),
        .m_status     (m_status),
        .m_entry_count(m_entry_count)
    );

    // Predictor state: a shadow copy of the sorted store.
    logic [63:0] shadow_set [DEPTH];
    int          shadow_count;

    set_op_t     pending_ops [$];
    set_reply_t  expected_replies [$];
    int          error_count;
    bit          stimulus_done;
    int          sent_count;
    // Long receiver hold-off is triggered once the sender is well underway.
    bit          hold_done;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Key that orders doubles as unsigned integers; both zeros share one key.
    function automatic logic [63:0] rank_key(input logic [63:0] b);
        if (b[62:0] == 63'd0) return 64'h8000_0000_0000_0000;
        if (b[63]) return ~b;
        return b | 64'h8000_0000_0000_0000;
    endfunction

    function automatic bit nan_bits(input logic [63:0] b);
        return b[62:0] > 63'h7FF0_0000_0000_0000;
    endfunction

    // Apply one item to the shadow store and queue the reply it must produce.
    task automatic predict_set_op(input set_op_t it);
        set_reply_t r;
        int         slot;
        bit         dup;
        r.read_bits = 64'd0;
        slot = shadow_count;
        dup = 1'b0;
        if (it.op == OP_READ) begin
            if (it.position >= 1 && it.position <= shadow_count) begin
                r.read_bits = shadow_set[it.position - 1];
                r.status = ST_READ_OK;
            end else begin
                r.read_bits = 64'hBFF0_0000_0000_0000;
                r.status = ST_BAD_POS;
            end
        end else begin
            for (int i = 0; i < shadow_count; i++) begin
                if (!nan_bits(it.value_bits) && !nan_bits(shadow_set[i])) begin
                    if (rank_key(shadow_set[i]) == rank_key(it.value_bits)) begin
                        dup = 1'b1;
                        break;
                    end
                    if (rank_key(it.value_bits) < rank_key(shadow_set[i])) begin
                        slot = i;
                        break;
                    end
                end
            end
            if (dup) begin
                r.status = ST_DUP;
            end else if (shadow_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (int j = shadow_count; j > slot; j--) shadow_set[j] = shadow_set[j - 1];
                shadow_set[slot] = it.value_bits;
                shadow_count++;
                r.status = ST_INSERTED;
            end
        end
        r.entry_count = 7'(shadow_count);
        expected_replies.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic set_op_t make_insert(input logic [63:0] v);
        set_op_t it;
        it.op = OP_INSERT;
        it.value_bits = v;
        it.position = 7'($urandom);
        return it;
    endfunction

    function automatic set_op_t make_read(input logic [6:0] p);
        set_op_t it;
        it.op = OP_READ;
        it.value_bits = {$urandom, $urandom};
        it.position = p;
        return it;
    endfunction

    // Draw a value, mostly from a small pool, so duplicates and equal zeros are common.
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = 64'h0000_0000_0000_0000;
            1: v = 64'h8000_0000_0000_0000;
            2: v = {1'($urandom), 11'($urandom_range(1020, 1030)), 52'($urandom_range(0, 7))};
            3: v = {1'($urandom), 11'($urandom_range(0, 2046)), $urandom, 20'($urandom)};
            4: v = {1'($urandom), 11'h7FF, 52'd0};
            default: v = {1'($urandom), 11'($urandom_range(1023, 1026)), 52'($urandom_range(0, 3))};
        endcase
        return v;
    endfunction

    // Fill the stimulus queue: directed items, then a random mix of inserts and
    // reads, some of the reads at positions out of range.
    initial begin
        pending_ops.push_back(make_read(7'd0));
        pending_ops.push_back(make_read(7'd1));
        pending_ops.push_back(make_insert(64'h0000_0000_0000_0000));
        pending_ops.push_back(make_insert(64'h8000_0000_0000_0000));
        pending_ops.push_back(make_insert(64'h3FF0_0000_0000_0000));
        pending_ops.push_back(make_insert(64'hBFF0_0000_0000_0000));
        pending_ops.push_back(make_insert(64'h7FF0_0000_0000_0000));
        pending_ops.push_back(make_insert(64'hFFF0_0000_0000_0000));
        pending_ops.push_back(make_insert(64'h7FEF_FFFF_FFFF_FFFF));
        pending_ops.push_back(make_insert(64'h0000_0000_0000_0001));
        pending_ops.push_back(make_insert(64'h8000_0000_0000_0001));
        pending_ops.push_back(make_insert(64'h3FF0_0000_0000_0000));
        pending_ops.push_back(make_read(7'd1));
        pending_ops.push_back(make_read(7'd4));
        pending_ops.push_back(make_read(7'd9));
        pending_ops.push_back(make_read(7'd10));
        pending_ops.push_back(make_read(7'd127));
        pending_ops.push_back(make_read(7'd64));
        // Fill to capacity, then probe full and duplicate-while-full.
        for (int i = 0; i < 60; i++)
            pending_ops.push_back(make_insert({12'h400, 52'(i) << 30}));
        pending_ops.push_back(make_insert(64'h4100_0000_0000_0000));
        pending_ops.push_back(make_insert(64'h3FF0_0000_0000_0000));
        pending_ops.push_back(make_read(7'd64));
        pending_ops.push_back(make_read(7'd65));
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(0, 2) == 0)
                pending_ops.push_back(make_read(7'($urandom_range(0, 70))));
            else if ($urandom_range(0, 9) == 0)
                pending_ops.push_back(make_read(7'($urandom)));
            else
                pending_ops.push_back(make_insert(pick_value()));
        end
        stimulus_done = 1'b1;
    end

    // Driver: hold each beat until accepted, with a random gap before each.
    int send_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= $urandom_range(0, 3);
        end else if (s_valid && !s_ready) begin
            // hold the offered beat
        end else begin
            if (s_valid) begin
                predict_set_op('{op_t'(s_mode), s_value_bits, s_position});
                sent_count <= sent_count + 1;
            end
            if (send_gap > 0 || pending_ops.size() == 0) begin
                s_valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                set_op_t it;
                it = pending_ops.pop_front();
                s_valid <= 1'b1;
                s_mode <= it.op;
                s_value_bits <= it.value_bits;
                s_position <= it.position;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            end
        end
    end

    // Monitor: check each result beat, then draw the next stall.
    int recv_gap;
    int hold_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected beat", m_read_bits, 64'd0);
                end else begin
                    set_reply_t w;
                    w = expected_replies.pop_front();
                    if (m_read_bits !== w.read_bits)
                        report_mismatch("read_bits", m_read_bits, w.read_bits);
                    if (m_status !== w.status)
                        report_mismatch("status", 64'(m_status), 64'(w.status));
                    if (m_entry_count !== w.entry_count)
                        report_mismatch("entry_count", 64'(m_entry_count),
                                        64'(w.entry_count));
                end
            end
            // Stall long once so the input side backs up.
            if (!hold_done && sent_count == 300) begin
                hold_done <= 1'b1;
                hold_left <= 8 * ITEM_CYCLES;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready || !m_ready) begin
                if (recv_gap > 0) begin
                    recv_gap <= recv_gap - 1;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
                end
            end
        end
    end

    initial begin
        error_count = 0;
        sent_count = 0;
        hold_done = 1'b0;
        shadow_count = 0;
        s_valid = 1'b0;
        s_mode = 1'b0;
        s_value_bits = 64'd0;
        s_position = 7'd0;
        m_ready = 1'b0;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stimulus_done && pending_ops.size() == 0);
        @(posedge aclk iff (!s_valid));
        @(posedge aclk iff (expected_replies.size() == 0));
        repeat (2 * ITEM_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog for the worst case: roughly 1300 items, each walking the whole cell row, plus stalls.
    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/susi_pkg.sv
hw/rtl/susi_cell.sv
hw/rtl/sorted_unique_set_insert_top.sv
tb/testbench.sv
